@@ hdl/pdps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdps_pkg
// Shared types, codes and defaults for the piezo drop pulse sequencer.
// ----------------------------------------------------------------------------
package pdps_pkg;

  localparam int TIME_BITS_DEFAULT  = 16;
  localparam int COUNT_BITS_DEFAULT = 16;

  localparam int DISCHARGE_RESET = 5000;
  localparam int FLOAT_RESET     = 10000;

  localparam int FUNC_W   = 2;
  localparam int CFG_ADDR_W = 1;
  localparam int OUT_W    = 8;

  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SINGLE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_BURST  = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_DISCHARGE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FLOAT     = 1'b1;

  // drop phases in order; ordinal 1..5 are the drive phases, 6 the gap
  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_FWD   = 7'b0000010,
    PH_FDIS  = 7'b0000100,
    PH_FLOAT = 7'b0001000,
    PH_REV   = 7'b0010000,
    PH_RDIS  = 7'b0100000,
    PH_GAP   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic drop;
    logic seq;
    logic rejected;
  } flags_t;

  function automatic logic [2:0] phase_ord(input phase_t ph);
    logic [2:0] r;
    unique case (ph)
      PH_IDLE:  r = 3'd0;
      PH_FWD:   r = 3'd1;
      PH_FDIS:  r = 3'd2;
      PH_FLOAT: r = 3'd3;
      PH_REV:   r = 3'd4;
      PH_RDIS:  r = 3'd5;
      PH_GAP:   r = 3'd6;
      default:  r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic phase_t ord_phase(input logic [2:0] ord);
    phase_t r;
    unique case (ord)
      3'd1:    r = PH_FWD;
      3'd2:    r = PH_FDIS;
      3'd3:    r = PH_FLOAT;
      3'd4:    r = PH_REV;
      3'd5:    r = PH_RDIS;
      3'd6:    r = PH_GAP;
      default: r = PH_IDLE;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/piezo_drop_pulse_sequencer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piezo_drop_pulse_sequencer_core
// Timed phase sequencer for the four bridge lines of a piezo drop nozzle.
//
//   channel  dir  tdata (low bit up)                 tuser
//   s_*      in   pulse_us, repeat_count, gap_us     func
//   m_*      out  line_orange, line_brown, line_blue,
//                 line_green, busy_res, drop_done,
//                 sequence_done, start_rejected      -
//   cfg_*    in   write: 0 discharge_time_us, 1 float_time_us
//
// One item per clock; the result of an item appears in the cycle after it
// is accepted. State update and result share one pass of next-state logic.
// Input stays ready while the result register is empty or being drained.
// rst is synchronous: idle, counters cleared, registers at their defaults.
// ----------------------------------------------------------------------------
module piezo_drop_pulse_sequencer_core #(
  parameter int TIME_BITS  = pdps_pkg::TIME_BITS_DEFAULT,
  parameter int COUNT_BITS = pdps_pkg::COUNT_BITS_DEFAULT,
  localparam int IN_W      = 2 * TIME_BITS + COUNT_BITS,
  localparam int IN_BYTES  = (IN_W + 7) / 8,
  localparam int IN_DATA_W = IN_BYTES * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [IN_DATA_W-1:0]              s_tdata,  // pulse_us, repeat_count, gap_us
  input  logic [pdps_pkg::FUNC_W-1:0]       s_tuser,  // func
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pdps_pkg::OUT_W-1:0]        m_tdata,  // orange, brown, blue, green,
                                                      // busy, drop, seq, rejected
  input  logic                              cfg_we,
  input  logic [pdps_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [TIME_BITS-1:0]              cfg_data
);

  logic                   accept;
  logic [TIME_BITS-1:0]   pulse_us;
  logic [COUNT_BITS-1:0]  repeat_count;
  logic [TIME_BITS-1:0]   gap_us;

  logic [TIME_BITS-1:0]   discharge_time;
  logic [TIME_BITS-1:0]   float_time;

  pdps_pkg::phase_t       phase;
  logic [TIME_BITS-1:0]   phase_ticks;
  logic [COUNT_BITS-1:0]  drops_left;
  logic [TIME_BITS-1:0]   held_pulse;
  logic [TIME_BITS-1:0]   held_gap;
  logic                   burst_mode;

  pdps_pkg::phase_t       phase_next;
  logic [TIME_BITS-1:0]   phase_ticks_next;
  logic [COUNT_BITS-1:0]  drops_left_next;
  logic [TIME_BITS-1:0]   held_pulse_next;
  logic [TIME_BITS-1:0]   held_gap_next;
  logic                   burst_mode_next;
  pdps_pkg::flags_t       flags;
  logic [pdps_pkg::OUT_W-1:0] result_next;

  assign pulse_us     = s_tdata[TIME_BITS-1:0];
  assign repeat_count = s_tdata[TIME_BITS +: COUNT_BITS];
  assign gap_us       = s_tdata[TIME_BITS+COUNT_BITS +: TIME_BITS];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  pdps_step #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .ph              (phase),
    .ticks           (phase_ticks),
    .drops_left      (drops_left),
    .held_pulse      (held_pulse),
    .held_gap        (held_gap),
    .burst_mode      (burst_mode),
    .func            (s_tuser),
    .pulse_us        (pulse_us),
    .repeat_count    (repeat_count),
    .gap_us          (gap_us),
    .discharge_time  (discharge_time),
    .float_time      (float_time),
    .ph_next         (phase_next),
    .ticks_next      (phase_ticks_next),
    .drops_left_next (drops_left_next),
    .held_pulse_next (held_pulse_next),
    .held_gap_next   (held_gap_next),
    .burst_mode_next (burst_mode_next),
    .flags           (flags)
  );

  always_comb begin
    result_next[0] = (phase_next == pdps_pkg::PH_REV);
    result_next[1] = (phase_next == pdps_pkg::PH_FDIS) || (phase_next == pdps_pkg::PH_REV) ||
                     (phase_next == pdps_pkg::PH_RDIS);
    result_next[2] = (phase_next == pdps_pkg::PH_FWD);
    result_next[3] = (phase_next == pdps_pkg::PH_FWD) || (phase_next == pdps_pkg::PH_FDIS) ||
                     (phase_next == pdps_pkg::PH_RDIS);
    result_next[4] = (phase_next != pdps_pkg::PH_IDLE);
    result_next[5] = flags.drop;
    result_next[6] = flags.seq;
    result_next[7] = flags.rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      discharge_time <= TIME_BITS'(pdps_pkg::DISCHARGE_RESET);
      float_time     <= TIME_BITS'(pdps_pkg::FLOAT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pdps_pkg::CFG_DISCHARGE: discharge_time <= cfg_data;
        pdps_pkg::CFG_FLOAT:     float_time     <= cfg_data;
        default:                 discharge_time <= discharge_time;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= pdps_pkg::PH_IDLE;
      phase_ticks <= '0;
      drops_left  <= '0;
      held_pulse  <= '0;
      held_gap    <= '0;
      burst_mode  <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      phase_ticks <= phase_ticks_next;
      drops_left  <= drops_left_next;
      held_pulse  <= held_pulse_next;
      held_gap    <= held_gap_next;
      burst_mode  <= burst_mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= result_next;
    end
  end

endmodule

@@ hdl/pdps_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdps_step
// Next-state logic of the sequencer for one item: tick, start or burst start.
// ----------------------------------------------------------------------------
module pdps_step #(
  parameter int TIME_BITS  = pdps_pkg::TIME_BITS_DEFAULT,
  parameter int COUNT_BITS = pdps_pkg::COUNT_BITS_DEFAULT
) (
  input  pdps_pkg::phase_t                   ph,
  input  logic [TIME_BITS-1:0]               ticks,
  input  logic [COUNT_BITS-1:0]              drops_left,
  input  logic [TIME_BITS-1:0]               held_pulse,
  input  logic [TIME_BITS-1:0]               held_gap,
  input  logic                               burst_mode,
  input  logic [pdps_pkg::FUNC_W-1:0]        func,
  input  logic [TIME_BITS-1:0]               pulse_us,
  input  logic [COUNT_BITS-1:0]              repeat_count,
  input  logic [TIME_BITS-1:0]               gap_us,
  input  logic [TIME_BITS-1:0]               discharge_time,
  input  logic [TIME_BITS-1:0]               float_time,
  output pdps_pkg::phase_t                   ph_next,
  output logic [TIME_BITS-1:0]               ticks_next,
  output logic [COUNT_BITS-1:0]              drops_left_next,
  output logic [TIME_BITS-1:0]               held_pulse_next,
  output logic [TIME_BITS-1:0]               held_gap_next,
  output logic                               burst_mode_next,
  output pdps_pkg::flags_t                   flags
);

  typedef struct packed {
    logic                  found;
    pdps_pkg::phase_t      ph;
    logic [TIME_BITS-1:0]  ticks;
  } load_t;

  typedef struct packed {
    pdps_pkg::phase_t      ph;
    logic [TIME_BITS-1:0]  ticks;
    logic [COUNT_BITS-1:0] dl;
    logic [TIME_BITS-1:0]  hp;
    logic [TIME_BITS-1:0]  hg;
    logic                  bm;
  } seq_state_t;

  // first nonzero phase at or after ordinal start (up to reverse discharge)
  function automatic load_t load_from(input logic [2:0] start,
                                      input logic [TIME_BITS-1:0] pulse,
                                      input logic [TIME_BITS-1:0] dis,
                                      input logic [TIME_BITS-1:0] flt);
    load_t r;
    logic [TIME_BITS-1:0] len;
    r.found = 1'b0;
    r.ph    = pdps_pkg::PH_IDLE;
    r.ticks = '0;
    for (int q = 5; q >= 1; q--) begin
      if (q == 1) begin
        len = pulse;
      end else if (q == 3) begin
        len = flt;
      end else begin
        len = dis;
      end
      if (3'(q) >= start && len != '0) begin
        r.found = 1'b1;
        r.ph    = pdps_pkg::ord_phase(3'(q));
        r.ticks = len;
      end
    end
    return r;
  endfunction

  function automatic seq_state_t seq_end(input seq_state_t s);
    seq_state_t r;
    r       = s;
    r.ph    = pdps_pkg::PH_IDLE;
    r.ticks = '0;
    r.dl    = '0;
    r.bm    = 1'b0;
    return r;
  endfunction

  function automatic seq_state_t drop_end(input seq_state_t s,
                                          input logic [TIME_BITS-1:0] dis,
                                          input logic [TIME_BITS-1:0] flt);
    seq_state_t r;
    load_t      ld;
    r    = s;
    r.dl = s.dl - COUNT_BITS'(1);
    ld   = load_from(3'd1, s.hp, dis, flt);
    if (r.bm && r.hg != '0) begin
      r.ph    = pdps_pkg::PH_GAP;
      r.ticks = r.hg;
    end else if (r.dl == '0) begin
      r = seq_end(r);
    end else if (ld.found) begin
      r.ph    = ld.ph;
      r.ticks = ld.ticks;
    end else begin
      r.ph    = pdps_pkg::PH_GAP;
      r.ticks = '0;
    end
    return r;
  endfunction

  seq_state_t           cur;
  seq_state_t           st;
  logic [TIME_BITS-1:0] dec;
  logic                 drive_ph;
  logic [COUNT_BITS-1:0] count;
  load_t                ld_next;
  load_t                ld_first;
  load_t                ld_start;

  assign cur.ph    = ph;
  assign cur.ticks = ticks;
  assign cur.dl    = drops_left;
  assign cur.hp    = held_pulse;
  assign cur.hg    = held_gap;
  assign cur.bm    = burst_mode;

  assign dec      = (ticks != '0) ? ticks - TIME_BITS'(1) : ticks;
  assign drive_ph = (ph != pdps_pkg::PH_IDLE) && (ph != pdps_pkg::PH_GAP);
  assign count    = (func == pdps_pkg::FUNC_BURST) ? repeat_count : COUNT_BITS'(1);

  assign ld_next  = load_from(pdps_pkg::phase_ord(ph) + 3'd1, held_pulse,
                              discharge_time, float_time);
  assign ld_first = load_from(3'd1, held_pulse, discharge_time, float_time);
  assign ld_start = load_from(3'd1, pulse_us, discharge_time, float_time);

  always_comb begin
    st             = cur;
    flags.drop     = 1'b0;
    flags.seq      = 1'b0;
    flags.rejected = 1'b0;
    if (func == pdps_pkg::FUNC_TICK) begin
      if (drive_ph) begin
        st.ticks = dec;
        if (dec == '0) begin
          if (ld_next.found) begin
            st.ph    = ld_next.ph;
            st.ticks = ld_next.ticks;
          end else begin
            st         = drop_end(st, discharge_time, float_time);
            flags.drop = 1'b1;
            flags.seq  = (st.ph == pdps_pkg::PH_IDLE);
          end
        end
      end else if (ph == pdps_pkg::PH_GAP) begin
        st.ticks = dec;
        if (dec == '0) begin
          if (drops_left == '0) begin
            st        = seq_end(st);
            flags.seq = 1'b1;
          end else if (ld_first.found) begin
            st.ph    = ld_first.ph;
            st.ticks = ld_first.ticks;
          end else begin
            st         = drop_end(st, discharge_time, float_time);
            flags.drop = 1'b1;
            flags.seq  = (st.ph == pdps_pkg::PH_IDLE);
          end
        end
      end
    end else if (func == pdps_pkg::FUNC_SINGLE || func == pdps_pkg::FUNC_BURST) begin
      if (ph != pdps_pkg::PH_IDLE) begin
        flags.rejected = 1'b1;
      end else if (count == '0) begin
        flags.seq = 1'b1;
      end else begin
        st.hp = pulse_us;
        st.hg = (func == pdps_pkg::FUNC_BURST) ? gap_us : '0;
        st.bm = (func == pdps_pkg::FUNC_BURST);
        st.dl = count;
        if (ld_start.found) begin
          st.ph    = ld_start.ph;
          st.ticks = ld_start.ticks;
        end else begin
          st         = drop_end(st, discharge_time, float_time);
          flags.drop = 1'b1;
          flags.seq  = (st.ph == pdps_pkg::PH_IDLE);
        end
      end
    end
  end

  assign ph_next         = st.ph;
  assign ticks_next      = st.ticks;
  assign drops_left_next = st.dl;
  assign held_pulse_next = st.hp;
  assign held_gap_next   = st.hg;
  assign burst_mode_next = st.bm;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for piezo_drop_pulse_sequencer_core. Ticks and
// single/burst starts are fed through the input stream. The expected line
// levels and done/reject flags are worked out by a cycle-free model of the
// nozzle phase sequence and compared field by field with each output item.
// Both stream sides idle at random. Timing registers are rewritten between
// runs of stimulus, some of them while a drop is still in progress.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          TB_TIME_BITS  = 16;
  localparam int          TB_COUNT_BITS = 16;
  localparam int          IN_DATA_W     = ((2 * TB_TIME_BITS + TB_COUNT_BITS + 7) / 8) * 8;
  localparam logic [1:0]  FUNC_IGNORED  = 2'd3;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int          SEGMENTS      = 11;
  localparam int          SEG_ITEMS     = 150;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] gap;
    logic [15:0] count;
    logic [15:0] pulse;
  } nozzle_cmd_t;

  // bit 0 is line_orange
  typedef struct packed {
    logic rejected;
    logic seq;
    logic drop;
    logic busy;
    logic green;
    logic blue;
    logic brown;
    logic orange;
  } nozzle_lines_t;

  typedef struct packed {
    logic [15:0]      discharge;
    logic [15:0]      float_len;
    pdps_pkg::phase_t ph;
    logic [15:0]      ticks_left;
    logic [15:0]      drops_left;
    logic [15:0]      pulse_len;
    logic [15:0]      gap_len;
    logic             burst;
  } nozzle_state_t;

  logic                            clk;
  logic                            rst      = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [IN_DATA_W-1:0]            s_tdata  = '0;  // pulse_us, repeat_count, gap_us
  logic [pdps_pkg::FUNC_W-1:0]     s_tuser  = '0;  // func
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [pdps_pkg::OUT_W-1:0]      m_tdata;        // orange, brown, blue, green,
                                                   // busy, drop, seq, rejected
  logic                            cfg_we   = 1'b0;
  logic [pdps_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [TB_TIME_BITS-1:0]         cfg_data = '0;

  nozzle_cmd_t   pending_cmds[$];
  nozzle_lines_t expected_lines[$];
  nozzle_state_t plan_st;
  nozzle_state_t model_st;
  nozzle_cmd_t   sent_cmd;
  int unsigned   src_wait;
  int unsigned   snk_wait;
  logic          src_idle_on = 1'b1;
  logic          snk_idle_on = 1'b1;
  int unsigned   mismatches  = 0;
  int unsigned   result_idx  = 0;
  int unsigned   cycle_count = 0;

  piezo_drop_pulse_sequencer_core #(
    .TIME_BITS (TB_TIME_BITS),
    .COUNT_BITS(TB_COUNT_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .cfg_we  (cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [15:0] phase_length(input nozzle_state_t s,
                                               input pdps_pkg::phase_t p);
    case (p)
      pdps_pkg::PH_FWD:   return s.pulse_len;
      pdps_pkg::PH_FDIS,
      pdps_pkg::PH_REV,
      pdps_pkg::PH_RDIS:  return s.discharge;
      pdps_pkg::PH_FLOAT: return s.float_len;
      default:            return 16'd0;
    endcase
  endfunction

  function automatic pdps_pkg::phase_t phase_after(input pdps_pkg::phase_t p);
    case (p)
      pdps_pkg::PH_FWD:   return pdps_pkg::PH_FDIS;
      pdps_pkg::PH_FDIS:  return pdps_pkg::PH_FLOAT;
      pdps_pkg::PH_FLOAT: return pdps_pkg::PH_REV;
      pdps_pkg::PH_REV:   return pdps_pkg::PH_RDIS;
      default:            return pdps_pkg::PH_GAP;
    endcase
  endfunction

  // first drive phase at or after p with a nonzero length
  function automatic logic enter_drive_phase(inout nozzle_state_t s,
                                             input pdps_pkg::phase_t p);
    pdps_pkg::phase_t q;
    q = p;
    while (q != pdps_pkg::PH_GAP) begin
      if (phase_length(s, q) != 16'd0) begin
        s.ph         = q;
        s.ticks_left = phase_length(s, q);
        return 1'b1;
      end
      q = phase_after(q);
    end
    return 1'b0;
  endfunction

  function automatic void close_sequence(inout nozzle_state_t s, inout nozzle_lines_t r);
    s.ph         = pdps_pkg::PH_IDLE;
    s.ticks_left = '0;
    s.drops_left = '0;
    s.burst      = 1'b0;
    r.seq        = 1'b1;
  endfunction

  function automatic void close_drop(inout nozzle_state_t s, inout nozzle_lines_t r);
    r.drop       = 1'b1;
    s.drops_left = s.drops_left - 16'd1;
    if (s.burst && s.gap_len != 16'd0) begin
      s.ph         = pdps_pkg::PH_GAP;
      s.ticks_left = s.gap_len;
    end else if (s.drops_left == 16'd0) begin
      close_sequence(s, r);
    end else if (!enter_drive_phase(s, pdps_pkg::PH_FWD)) begin
      // empty drop with no gap: park one tick in the gap phase
      s.ph         = pdps_pkg::PH_GAP;
      s.ticks_left = '0;
    end
  endfunction

  function automatic void advance_tick(inout nozzle_state_t s, inout nozzle_lines_t r);
    if (s.ph == pdps_pkg::PH_GAP) begin
      if (s.ticks_left != 16'd0) s.ticks_left = s.ticks_left - 16'd1;
      if (s.ticks_left == 16'd0) begin
        if (s.drops_left == 16'd0) close_sequence(s, r);
        else if (!enter_drive_phase(s, pdps_pkg::PH_FWD)) close_drop(s, r);
      end
    end else if (s.ph != pdps_pkg::PH_IDLE) begin
      if (s.ticks_left != 16'd0) s.ticks_left = s.ticks_left - 16'd1;
      if (s.ticks_left == 16'd0 && !enter_drive_phase(s, phase_after(s.ph)))
        close_drop(s, r);
    end
  endfunction

  function automatic nozzle_lines_t nozzle_step(inout nozzle_state_t s, input nozzle_cmd_t c);
    nozzle_lines_t r;
    r = '0;
    case (c.func)
      pdps_pkg::FUNC_TICK: begin
        advance_tick(s, r);
      end
      pdps_pkg::FUNC_SINGLE, pdps_pkg::FUNC_BURST: begin
        if (s.ph != pdps_pkg::PH_IDLE) begin
          r.rejected = 1'b1;
        end else if (c.func == pdps_pkg::FUNC_BURST && c.count == 16'd0) begin
          r.seq = 1'b1;
        end else begin
          s.pulse_len  = c.pulse;
          s.gap_len    = (c.func == pdps_pkg::FUNC_BURST) ? c.gap : 16'd0;
          s.burst      = (c.func == pdps_pkg::FUNC_BURST);
          s.drops_left = (c.func == pdps_pkg::FUNC_BURST) ? c.count : 16'd1;
          if (!enter_drive_phase(s, pdps_pkg::PH_FWD)) close_drop(s, r);
        end
      end
      default: ;
    endcase
    r.orange = (s.ph == pdps_pkg::PH_REV);
    r.brown  = (s.ph == pdps_pkg::PH_FDIS) || (s.ph == pdps_pkg::PH_REV) ||
               (s.ph == pdps_pkg::PH_RDIS);
    r.blue   = (s.ph == pdps_pkg::PH_FWD);
    r.green  = (s.ph == pdps_pkg::PH_FWD) || (s.ph == pdps_pkg::PH_FDIS) ||
               (s.ph == pdps_pkg::PH_RDIS);
    r.busy   = (s.ph != pdps_pkg::PH_IDLE);
    return r;
  endfunction

  // ---------------------------------------------------------------- helpers
  function automatic int unsigned draw_wait(input logic on);
    return on ? $urandom_range(0, 14) : 0;
  endfunction

  function automatic logic [15:0] rnd16();
    logic [31:0] v;
    v = $urandom;
    return v[15:0];
  endfunction

  function automatic logic [15:0] pick_len(input int unsigned hi);
    logic [31:0] v;
    if ($urandom_range(0, 49) == 0) v = $urandom_range(60, 200);
    else if ($urandom_range(0, 3) == 0) v = 0;
    else v = $urandom_range(1, hi);
    return v[15:0];
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("%0t item %0d: %s expected %0d got %0d", $time, result_idx, what, want, got);
    mismatches++;
  endtask

  task automatic push_cmd(input logic [1:0] f, input logic [15:0] p,
                          input logic [15:0] n, input logic [15:0] g);
    nozzle_cmd_t   c;
    nozzle_lines_t ignored;
    c.func  = f;
    c.pulse = p;
    c.count = n;
    c.gap   = g;
    ignored = nozzle_step(plan_st, c);
    pending_cmds.push_back(c);
  endtask

  task automatic tick_to(input pdps_pkg::phase_t p);
    while (plan_st.ph != p) push_cmd(pdps_pkg::FUNC_TICK, rnd16(), rnd16(), rnd16());
  endtask

  task automatic settle();
    while (pending_cmds.size() != 0 || s_tvalid || expected_lines.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pdps_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [15:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    if (idx == pdps_pkg::CFG_DISCHARGE) begin
      plan_st.discharge  = val;
      model_st.discharge = val;
    end else begin
      plan_st.float_len  = val;
      model_st.float_len = val;
    end
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin : source
    nozzle_cmd_t c;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= pdps_pkg::FUNC_TICK;
      src_wait <= 0;
    end else begin
      if (s_tvalid && s_tready)
        expected_lines.push_back(nozzle_step(model_st, sent_cmd));
      if (!s_tvalid || s_tready) begin
        if (src_wait != 0) begin
          src_wait <= src_wait - 1;
          s_tvalid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          c = pending_cmds.pop_front();
          sent_cmd <= c;
          s_tdata  <= {c.gap, c.count, c.pulse};
          s_tuser  <= c.func;
          s_tvalid <= 1'b1;
          src_wait <= draw_wait(src_idle_on);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : sink
    int unsigned   w;
    nozzle_lines_t want;
    nozzle_lines_t got;
    if (rst) begin
      m_tready <= 1'b0;
      snk_wait <= 0;
    end else begin
      w = snk_wait;
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_lines.size() == 0) begin
          report_mismatch("item with nothing pending, data", 0, m_tdata);
        end else begin
          want = expected_lines.pop_front();
          if (got.orange   !== want.orange)   report_mismatch("line_orange", want.orange, got.orange);
          if (got.brown    !== want.brown)    report_mismatch("line_brown", want.brown, got.brown);
          if (got.blue     !== want.blue)     report_mismatch("line_blue", want.blue, got.blue);
          if (got.green    !== want.green)    report_mismatch("line_green", want.green, got.green);
          if (got.busy     !== want.busy)     report_mismatch("busy_res", want.busy, got.busy);
          if (got.drop     !== want.drop)     report_mismatch("drop_done", want.drop, got.drop);
          if (got.seq      !== want.seq)      report_mismatch("sequence_done", want.seq, got.seq);
          if (got.rejected !== want.rejected) report_mismatch("start_rejected", want.rejected,
                                                              got.rejected);
        end
        result_idx++;
        w = draw_wait(snk_idle_on);
      end
      if (w != 0) begin
        snk_wait <= w - 1;
        m_tready <= 1'b0;
      end else begin
        snk_wait <= 0;
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin : stimulus
    int unsigned counted;
    int unsigned sel;
    logic [15:0] dis;
    logic [15:0] flt;
    logic [31:0] v;

    plan_st            = '0;
    plan_st.discharge  = pdps_pkg::DISCHARGE_RESET[15:0];
    plan_st.float_len  = pdps_pkg::FLOAT_RESET[15:0];
    plan_st.ph         = pdps_pkg::PH_IDLE;
    model_st           = plan_st;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // idle noise, empty burst with extreme fields, rejects while busy
    push_cmd(pdps_pkg::FUNC_TICK, 16'hffff, 16'hffff, 16'hffff);
    push_cmd(FUNC_IGNORED, 16'h0000, 16'h0000, 16'h0000);
    push_cmd(pdps_pkg::FUNC_BURST, 16'hffff, 16'h0000, 16'hffff);
    push_cmd(pdps_pkg::FUNC_SINGLE, 16'd1, 16'd0, 16'd0);
    push_cmd(pdps_pkg::FUNC_BURST, 16'hffff, 16'hffff, 16'hffff);
    push_cmd(pdps_pkg::FUNC_SINGLE, 16'hffff, 16'hffff, 16'hffff);
    push_cmd(FUNC_IGNORED, 16'hffff, 16'hffff, 16'hffff);
    settle();
    write_reg(pdps_pkg::CFG_DISCHARGE, 16'd0);
    write_reg(pdps_pkg::CFG_FLOAT, 16'd0);

    // all later phases empty; empty drops, one finishing per tick when there is no gap
    push_cmd(pdps_pkg::FUNC_TICK, 16'd0, 16'd0, 16'd0);
    push_cmd(pdps_pkg::FUNC_SINGLE, 16'd0, 16'd0, 16'd0);
    push_cmd(pdps_pkg::FUNC_BURST, 16'd0, 16'd3, 16'd0);
    tick_to(pdps_pkg::PH_IDLE);
    push_cmd(pdps_pkg::FUNC_BURST, 16'd0, 16'd2, 16'd2);
    tick_to(pdps_pkg::PH_IDLE);
    settle();
    write_reg(pdps_pkg::CFG_DISCHARGE, 16'd2);
    write_reg(pdps_pkg::CFG_FLOAT, 16'd1);

    // registers rewritten mid-drop, after their last use
    push_cmd(pdps_pkg::FUNC_SINGLE, 16'd2, 16'd0, 16'd0);
    tick_to(pdps_pkg::PH_RDIS);
    settle();
    write_reg(pdps_pkg::CFG_FLOAT, 16'hffff);
    tick_to(pdps_pkg::PH_IDLE);
    settle();
    write_reg(pdps_pkg::CFG_FLOAT, 16'd1);
    push_cmd(pdps_pkg::FUNC_BURST, 16'd1, 16'd1, 16'd3);
    tick_to(pdps_pkg::PH_GAP);
    settle();
    write_reg(pdps_pkg::CFG_DISCHARGE, 16'hffff);
    tick_to(pdps_pkg::PH_IDLE);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      case (seg)
        0: begin dis = 16'd0; flt = 16'd0; end
        1: begin dis = 16'd1; flt = 16'd0; end
        2: begin dis = 16'd0; flt = 16'd3; end
        3: begin dis = 16'd25; flt = 16'd2; end
        default: begin
          v   = $urandom_range(0, 6);
          dis = v[15:0];
          v   = $urandom_range(0, 6);
          flt = v[15:0];
        end
      endcase
      write_reg(pdps_pkg::CFG_DISCHARGE, dis);
      write_reg(pdps_pkg::CFG_FLOAT, flt);
      src_idle_on = (seg % 4) != 1;
      snk_idle_on = (seg % 4) != 2;

      counted = 0;
      while (counted < SEG_ITEMS) begin
        sel = $urandom_range(0, 99);
        if (plan_st.ph == pdps_pkg::PH_IDLE) begin
          if (sel < 8) begin
            push_cmd(($urandom_range(0, 1) != 0) ? FUNC_IGNORED : pdps_pkg::FUNC_TICK,
                     rnd16(), rnd16(), rnd16());
          end else if (sel < 40) begin
            push_cmd(pdps_pkg::FUNC_SINGLE, pick_len(8), rnd16(), rnd16());
            counted++;
          end else if (sel < 45) begin
            push_cmd(pdps_pkg::FUNC_BURST, rnd16(), 16'd0, rnd16());
            counted++;
          end else begin
            v = $urandom_range(1, 4);
            push_cmd(pdps_pkg::FUNC_BURST, pick_len(8), v[15:0], pick_len(5));
            counted++;
          end
        end else begin
          if (sel < 90) begin
            push_cmd(pdps_pkg::FUNC_TICK, rnd16(), rnd16(), rnd16());
            counted++;
          end else if (sel < 96) begin
            push_cmd(($urandom_range(0, 1) != 0) ? pdps_pkg::FUNC_BURST
                                                 : pdps_pkg::FUNC_SINGLE,
                     rnd16(), rnd16(), rnd16());
            counted++;
          end else begin
            push_cmd(FUNC_IGNORED, rnd16(), rnd16(), rnd16());
          end
        end
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_lines.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/pdps_pkg.sv
hdl/pdps_step.sv
hdl/piezo_drop_pulse_sequencer_core.sv
test/tb_top.sv
